// ----- rtl/core/checksummed_frame_receiver_top_assert.svh -----
// ----------------------------------------------------------------------------
// Checksummed frame receiver assertion macros
// Shared concurrent assertion forms used by the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef CHECKSUMMED_FRAME_RECEIVER_TOP_ASSERT_SVH
`define CHECKSUMMED_FRAME_RECEIVER_TOP_ASSERT_SVH

// same-cycle implication
`define CFR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/cfr_pkg.sv -----
// ----------------------------------------------------------------------------
// Checksummed frame receiver package
// Shared codes, constants and transfer types of the receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   // register indexes
   localparam logic REG_CHECKSUM_MODE  = 1'b0;
   localparam logic REG_FRAME_CAPACITY = 1'b1;

   localparam logic [1:0]  CHECKSUM_MODE_RESET  = 2'd0;
   localparam logic [15:0] FRAME_CAPACITY_RESET = 16'd1024;

   // checksum modes
   localparam logic [1:0] MODE_SUM8     = 2'd0;
   localparam logic [1:0] MODE_SUM16    = 2'd1;
   localparam logic [1:0] MODE_NEG_SUM8 = 2'd2;
   localparam logic [1:0] MODE_NONE     = 2'd3;

   // operations
   localparam logic OP_RECEIVE = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   // receiver phases
   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_START1   = 3'd1;
   localparam logic [2:0] PH_DIR      = 3'd2;
   localparam logic [2:0] PH_LENH     = 3'd3;
   localparam logic [2:0] PH_LENL     = 3'd4;
   localparam logic [2:0] PH_PAYLOAD  = 3'd5;
   localparam logic [2:0] PH_COMPLETE = 3'd6;
   localparam logic [2:0] PH_ERROR    = 3'd7;

   localparam logic [7:0] SYNC_A    = 8'h46;
   localparam logic [7:0] SYNC_B    = 8'hB9;
   localparam logic [7:0] END_MARK  = 8'h16;
   localparam logic [7:0] BYTE_MASK = 8'hFF;

   typedef struct packed {
      logic [1:0]  checksum_mode;
      logic [15:0] frame_capacity;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  rx_state;
      logic [15:0] byte_count;
      logic [7:0]  data_byte;
      logic        is_payload;
      logic [7:0]  direction;
      logic        checksum_ok;
      logic        length_bad;
      logic        overflow;
   } result_type;

endpackage

// ----- rtl/core/cfr_csr.sv -----
// ----------------------------------------------------------------------------
// Checksummed frame receiver register block
// APB-style write and read of the checksum mode and frame capacity.
// ----------------------------------------------------------------------------
module cfr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [cfr_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [cfr_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [cfr_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output cfr_pkg::cfg_type                     cfg
);
   import cfr_pkg::*;

   logic [1:0]  mode_ff, mode_in;
   logic [15:0] cap_ff, cap_in;
   logic        wr_en;
   logic        reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      mode_in = mode_ff;
      cap_in  = cap_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_CHECKSUM_MODE:  mode_in = csr_pwdata[1:0];
            REG_FRAME_CAPACITY: cap_in  = csr_pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_CHECKSUM_MODE:  csr_prdata = {30'd0, mode_ff};
         REG_FRAME_CAPACITY: csr_prdata = {16'd0, cap_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= CHECKSUM_MODE_RESET;
         cap_ff  <= FRAME_CAPACITY_RESET;
      end else begin
         mode_ff <= mode_in;
         cap_ff  <= cap_in;
      end
   end

   assign cfg.checksum_mode  = mode_ff;
   assign cfg.frame_capacity = cap_ff;

endmodule

// ----- rtl/core/cfr_parser.sv -----
// ----------------------------------------------------------------------------
// Checksummed frame receiver parser
// Frame state, running checksum and per-byte result logic.
// ----------------------------------------------------------------------------
module cfr_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 operation,
   input  logic [7:0]           rx_byte,
   input  cfr_pkg::cfg_type     cfg,
   output cfr_pkg::result_type  result
);
   import cfr_pkg::*;

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  dir_ff, dir_in;
   logic [15:0] sum_ff, sum_in;
   logic [15:0] rcv_ff, rcv_in;
   logic        ovf_ff, ovf_in;

   logic [15:0] cnt_inc;
   logic [1:0]  sum_bytes;
   logic        payload_now;
   logic [7:0]  echo;
   logic        len_short;
   logic        len_known;
   logic [15:0] got_sum;
   logic [15:0] exp_sum;

   assign sum_bytes = (cfg.checksum_mode == MODE_SUM16) ? 2'd2 : 2'd1;
   assign cnt_inc   = count_ff + 16'd1;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      length_in   = length_ff;
      dir_in      = dir_ff;
      sum_in      = sum_ff;
      rcv_in      = rcv_ff;
      ovf_in      = ovf_ff;
      payload_now = 1'b0;
      echo        = rx_byte;
      if (operation == OP_RESTART) begin
         phase_in  = PH_IDLE;
         count_in  = '0;
         length_in = '0;
         dir_in    = '0;
         sum_in    = '0;
         rcv_in    = '0;
         ovf_in    = 1'b0;
         echo      = '0;
      end else if (phase_ff != PH_COMPLETE && phase_ff != PH_ERROR) begin
         if (count_ff >= cfg.frame_capacity) begin
            phase_in = PH_ERROR;
            ovf_in   = 1'b1;
         end else begin
            count_in = cnt_inc;
            unique case (phase_ff)
               PH_IDLE: begin
                  if (rx_byte == SYNC_A) begin
                     phase_in = PH_START1;
                  end else begin
                     count_in = '0;
                  end
               end
               PH_START1: begin
                  if (rx_byte == SYNC_B) begin
                     phase_in = PH_DIR;
                  end else if (rx_byte == SYNC_A) begin
                     count_in = 16'd1;
                  end else begin
                     phase_in = PH_IDLE;
                     count_in = '0;
                  end
               end
               PH_DIR: begin
                  dir_in   = rx_byte;
                  sum_in   = sum_ff + {8'd0, rx_byte};
                  phase_in = PH_LENH;
               end
               PH_LENH: begin
                  length_in = {rx_byte, 8'd0};
                  sum_in    = sum_ff + {8'd0, rx_byte};
                  phase_in  = PH_LENL;
               end
               PH_LENL: begin
                  length_in = {length_ff[15:8], rx_byte};
                  sum_in    = sum_ff + {8'd0, rx_byte};
                  phase_in  = PH_PAYLOAD;
               end
               default: begin
                  if ({1'b0, cnt_inc} >= ({1'b0, length_ff} + 17'd3)) begin
                     phase_in = (rx_byte == END_MARK) ? PH_COMPLETE : PH_ERROR;
                  end else if (({1'b0, cnt_inc} + {15'd0, sum_bytes})
                               <= ({1'b0, length_ff} + 17'd2)) begin
                     sum_in      = sum_ff + {8'd0, rx_byte};
                     payload_now = 1'b1;
                  end else begin
                     rcv_in = {rcv_ff[7:0], rx_byte};
                  end
               end
            endcase
         end
      end
   end

   assign len_short = length_in < (16'd3 + {14'd0, sum_bytes});
   assign len_known = (phase_in >= PH_PAYLOAD) && (count_in >= 16'd5);
   assign got_sum   = (sum_bytes == 2'd2) ? rcv_in : {8'd0, rcv_in[7:0] & BYTE_MASK};

   always_comb begin
      case (cfg.checksum_mode)
         MODE_SUM8:     exp_sum = {8'd0, sum_in[7:0]};
         MODE_SUM16:    exp_sum = sum_in;
         MODE_NEG_SUM8: exp_sum = {8'd0, 8'd0 - sum_in[7:0]};
         default:       exp_sum = '0;
      endcase
   end

   assign result.rx_state    = phase_in;
   assign result.byte_count  = count_in;
   assign result.data_byte   = echo;
   assign result.is_payload  = payload_now;
   assign result.direction   = dir_in;
   assign result.checksum_ok = (phase_in == PH_COMPLETE) && !len_short && (got_sum == exp_sum);
   assign result.length_bad  = len_known && len_short;
   assign result.overflow    = ovf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         count_ff  <= '0;
         length_ff <= '0;
         dir_ff    <= '0;
         sum_ff    <= '0;
         rcv_ff    <= '0;
         ovf_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         dir_ff    <= dir_in;
         sum_ff    <= sum_in;
         rcv_ff    <= rcv_in;
         ovf_ff    <= ovf_in;
      end
   end

`include "checksummed_frame_receiver_top_assert.svh"

   `CFR_ASSERT_NOW(a_ovf_in_error, clock, reset, ovf_ff, phase_ff == PH_ERROR, "overflow set outside error")
   `CFR_ASSERT_NEXT(a_restart_clears, clock, reset, advance && operation == OP_RESTART, phase_ff == PH_IDLE && count_ff == 16'd0 && !ovf_ff, "restart did not clear frame state")
   `CFR_ASSERT_NEXT(a_complete_sticky, clock, reset, advance && operation == OP_RECEIVE && phase_ff == PH_COMPLETE, phase_ff == PH_COMPLETE && $stable(count_ff), "complete state left without restart")

endmodule

// ----- rtl/core/checksummed_frame_receiver_top.sv -----
// ----------------------------------------------------------------------------
// Checksummed frame receiver top level
// Input register, frame parser and result register with valid/stall channels.
// ----------------------------------------------------------------------------
// Takes one received byte (or a restart) per transfer and returns one result
// per transfer. A new byte is accepted every clock cycle while req_stall is
// low; each byte passes an input register, the frame parser and a result
// register. The result register decouples the two channels: a byte is still
// taken while a finished result waits, and req_stall rises only when both
// registers are full and rsp_stall is high. Configure checksum mode and
// frame capacity through the csr port only while no transfer is in flight.
module checksummed_frame_receiver_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_operation,
   input  logic [7:0]                           req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [2:0]                           rsp_rx_state,
   output logic [15:0]                          rsp_byte_count,
   output logic [7:0]                           rsp_data_byte,
   output logic                                 rsp_is_payload,
   output logic [7:0]                           rsp_direction,
   output logic                                 rsp_checksum_ok,
   output logic                                 rsp_length_bad,
   output logic                                 rsp_overflow,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [cfr_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [cfr_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [cfr_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import cfr_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type out_ff;

   logic       in_valid_ff, in_valid_in;
   logic       in_op_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   logic       out_blocked;
   logic       advance;
   logic       req_take;

   assign out_blocked = out_valid_ff && rsp_stall;
   assign advance     = in_valid_ff && !out_blocked;
   assign req_stall   = in_valid_ff && out_blocked;
   assign req_take    = req_valid && !req_stall;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = advance ? 1'b1 : (out_blocked ? 1'b1 : 1'b0);

   cfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .operation (in_op_ff),
      .rx_byte   (in_byte_ff),
      .cfg       (cfg),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_operation;
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_rx_state    = out_ff.rx_state;
   assign rsp_byte_count  = out_ff.byte_count;
   assign rsp_data_byte   = out_ff.data_byte;
   assign rsp_is_payload  = out_ff.is_payload;
   assign rsp_direction   = out_ff.direction;
   assign rsp_checksum_ok = out_ff.checksum_ok;
   assign rsp_length_bad  = out_ff.length_bad;
   assign rsp_overflow    = out_ff.overflow;

endmodule
